// File: rtl/gb5_pkg.sv
// ----------------------------------------------------------------------------
// gb5_pkg: shared types and constants of the 5x5 Gaussian filter
// Kernel weights, divisor and the register index codes.
// ----------------------------------------------------------------------------
`default_nettype none
package gb5_pkg;
	localparam int unsigned KERNEL_TOTAL = 273;
	localparam int unsigned HEIGHT_LIMIT = 4096;
	localparam int unsigned WIDTH_BITS   = 11;
	localparam int unsigned HEIGHT_BITS  = 13;
	localparam int unsigned CFG_BITS     = 13;
	localparam int unsigned IDX_BITS     = 1;

	typedef enum logic [IDX_BITS-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [5:0] weight_t;

	function automatic weight_t kernel_weight(input int r, input int c);
		int rr;
		int cc;
		rr = (r > 2) ? 4 - r : r;
		cc = (c > 2) ? 4 - c : c;
		case (rr * 3 + cc)
			0: kernel_weight = 6'd1;
			1: kernel_weight = 6'd4;
			2: kernel_weight = 6'd7;
			3: kernel_weight = 6'd4;
			4: kernel_weight = 6'd16;
			5: kernel_weight = 6'd26;
			6: kernel_weight = 6'd7;
			7: kernel_weight = 6'd26;
			8: kernel_weight = 6'd41;
			default: kernel_weight = 6'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// File: rtl/gb5_stream_if.sv
// ----------------------------------------------------------------------------
// gb5_stream_if: valid/ready channel with a payload struct
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface gb5_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/gaussian_blur_5x5.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5: streaming 5x5 Gaussian filter over raster-order frames
//
// Input channel in_ch carries one word per stream position: pixel and drain.
// A drain word feeds the value zero; after each frame of W*H pixels send
// 2*W+2 drain words to flush the last results out.
// Output channel out_ch carries filtered_pixel, out_row, out_column and
// last_of_frame. The result for frame position q leaves with the word at
// stream position q+2W+2, then passes stages 1 to 4 and the output register.
// Throughput is one word per clock unless out_ch stalls or cfg_we is high:
// the four line stores sit in a single RAM row of 4*PIXEL_BITS bits, read and
// written once per word, with a forwarding path for a column touched by two
// adjacent words (width one). The weighted sum takes two stages, the divide by
// 273 a reciprocal multiply and one correction stage.
// Reset clears the position counters, the window and the pipeline valids;
// frame_width goes to 640 and frame_height to 480. Line store contents are
// undefined after reset and only reach border taps. A stalled receiver holds
// the output register; the pipeline advances only while it can drain.
// Register writes restart the frame counters.
// ----------------------------------------------------------------------------
`default_nettype none
module gaussian_blur_5x5 import gb5_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	gb5_stream_if.sink                 in_ch,
	gb5_stream_if.source               out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_BITS-1:0]   cfg_data
);
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int RW = 4 * PIXEL_BITS;
	localparam int SB = PIXEL_BITS + 10;
	localparam int MB = SB + 17;

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [13:0] w_eff;
	logic [12:0] h_eff;
	always_comb begin
		w_eff = (width_q == '0) ? 14'd1 :
			((32'(width_q) > MAX_WIDTH) ? 14'(MAX_WIDTH) : 14'(width_q));
		h_eff = (height_q == '0) ? 13'd1 :
			((height_q > 13'(HEIGHT_LIMIT)) ? 13'(HEIGHT_LIMIT) : height_q);
	end

	logic adv;
	logic acc;
	assign acc = in_ch.valid && in_ch.ready;

	logic [13:0] in_col_q;
	logic [13:0] out_col_q;
	logic [12:0] out_row_q;

	logic [CB-1:0] col_idx;
	assign col_idx = (in_col_q >= w_eff) ? '0 : in_col_q[CB-1:0];

	logic [PIXEL_BITS-1:0] value;
	assign value = in_ch.data.drain ? '0 : in_ch.data.pixel[PIXEL_BITS-1:0];

	// stage 1: RAM read in flight
	logic                  v_s1;
	logic [PIXEL_BITS-1:0] val_s1;
	logic [CB-1:0]         col_s1;
	logic                  emit_s1;
	logic [11:0]           orow_s1;
	logic [9:0]            ocol_s1;
	logic                  int_s1;
	logic                  last_s1;
	logic [RW-1:0]         rd_data;
	logic [RW-1:0]         row_s1;
	logic [RW-1:0]         wr_row;
	logic                  fwd_q;
	logic [RW-1:0]         fwd_row_q;

	gb5_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (v_s1 && adv),
		.waddr (col_s1),
		.wdata (wr_row),
		.re    (acc),
		.raddr (col_idx),
		.rdata (rd_data)
	);

	assign row_s1 = fwd_q ? fwd_row_q : rd_data;
	assign wr_row = {val_s1, row_s1[RW-1:PIXEL_BITS]};

	logic last_now;
	logic intr_now;
	logic emit_c;
	logic [13:0] w2;
	assign w2 = w_eff << 1;
	logic [15:0] lag_tgt;
	assign lag_tgt = 16'(w2) + 16'd2;
	logic [15:0] lagc_q;
	assign emit_c = (lagc_q >= lag_tgt);
	assign last_now = (out_row_q == h_eff - 13'd1) && (out_col_q == w_eff - 14'd1);
	assign intr_now = (out_row_q >= 13'd2) && (14'(out_row_q) + 14'd2 < 14'(h_eff)) &&
		(out_col_q >= 14'd2) && (out_col_q + 14'd2 < w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 11'd640;
			height_q  <= 13'd480;
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lagc_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data[WIDTH_BITS-1:0];
			end else begin
				height_q <= cfg_data;
			end
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lagc_q    <= '0;
		end else if (acc) begin
			if (emit_c && last_now) begin
				in_col_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				lagc_q    <= '0;
			end else begin
				if (14'(col_idx) + 14'd1 >= w_eff) begin
					in_col_q <= '0;
				end else begin
					in_col_q <= 14'(col_idx) + 14'd1;
				end
				if (!emit_c) begin
					lagc_q <= lagc_q + 16'd1;
				end else if (out_col_q + 14'd1 >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 13'd1;
				end else begin
					out_col_q <= out_col_q + 14'd1;
				end
			end
		end
	end

	logic fwd_d;
	assign fwd_d = acc && v_s1 && (col_s1 == col_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			fwd_q <= 1'b0;
		end else if (adv) begin
			v_s1  <= acc;
			fwd_q <= fwd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1    <= value;
			col_s1    <= col_idx;
			emit_s1   <= emit_c;
			orow_s1   <= out_row_q[11:0];
			ocol_s1   <= out_col_q[9:0];
			int_s1    <= intr_now;
			last_s1   <= last_now;
			fwd_row_q <= wr_row;
		end
	end

	// window shift at stage 1
	logic [PIXEL_BITS-1:0] win_q [5][5];
	logic [PIXEL_BITS-1:0] vec [5];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vec[k] = row_s1[k*PIXEL_BITS +: PIXEL_BITS];
		end
		vec[4] = val_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 5; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (adv && v_s1) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 4; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][4] <= vec[r];
			end
		end
	end

	// stage 2: row sums of the window with the new column shifted in
	logic                  v_s2;
	logic [SB-1:0]         rsum_s2 [5];
	logic [PIXEL_BITS-1:0] ctr_s2;
	logic [11:0]           orow_s2;
	logic [9:0]            ocol_s2;
	logic                  int_s2;
	logic                  last_s2;

	logic [PIXEL_BITS-1:0] win_next [5][5];
	always_comb begin
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 4; c++) begin
				win_next[r][c] = win_q[r][c+1];
			end
			win_next[r][4] = vec[r];
		end
	end
	logic [SB-1:0] rsum_n [5];
	always_comb begin
		for (int r = 0; r < 5; r++) begin
			rsum_n[r] = '0;
			for (int c = 0; c < 5; c++) begin
				rsum_n[r] = rsum_n[r] + SB'(win_next[r][c]) * SB'(kernel_weight(r, c));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 5; r++) begin
				rsum_s2[r] <= rsum_n[r];
			end
			ctr_s2  <= win_next[2][2];
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
			int_s2  <= int_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: total and rounding bias, then reciprocal multiply
	localparam int unsigned RECIP = 2 ** 25 / KERNEL_TOTAL + 1;
	logic                  v_s3;
	logic [SB-1:0]         sum_s3;
	logic [PIXEL_BITS-1:0] ctr_s3;
	logic [11:0]           orow_s3;
	logic [9:0]            ocol_s3;
	logic                  int_s3;
	logic                  last_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= rsum_s2[0] + rsum_s2[1] + rsum_s2[2] + rsum_s2[3] + rsum_s2[4]
				+ SB'(KERNEL_TOTAL / 2);
			ctr_s3  <= ctr_s2;
			orow_s3 <= orow_s2;
			ocol_s3 <= ocol_s2;
			int_s3  <= int_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: quotient estimate and remainder check
	logic                  v_s4;
	logic [SB-1:0]         quo_s4;
	logic [SB-1:0]         sum_s4;
	logic [PIXEL_BITS-1:0] ctr_s4;
	logic [11:0]           orow_s4;
	logic [9:0]            ocol_s4;
	logic                  int_s4;
	logic                  last_s4;
	logic [MB+SB-1:0]      prod;
	assign prod = (MB+SB)'(sum_s3) * (MB+SB)'(RECIP);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			quo_s4  <= SB'(prod >> 25);
			sum_s4  <= sum_s3;
			ctr_s4  <= ctr_s3;
			orow_s4 <= orow_s3;
			ocol_s4 <= ocol_s3;
			int_s4  <= int_s3;
			last_s4 <= last_s3;
		end
	end

	logic [SB+9:0] back;
	logic [SB-1:0] quo_fix;
	assign back    = (SB+10)'(quo_s4) * (SB+10)'(KERNEL_TOTAL);
	assign quo_fix = (back > (SB+10)'(sum_s4)) ? quo_s4 - SB'(1) : quo_s4;

	// output register
	logic out_v_q;
	assign adv         = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv && !cfg_we;
	assign out_ch.valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.data.filtered_pixel <= int_s4 ? 16'(quo_fix) : 16'(ctr_s4);
			out_ch.data.out_row        <= orow_s4;
			out_ch.data.out_column     <= ocol_s4;
			out_ch.data.last_of_frame  <= last_s4;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("output word dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> !in_ch.ready)
		else $error("input taken while pipeline held");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !int_s4 && adv |=> out_ch.data.filtered_pixel == 16'($past(ctr_s4)))
		else $error("border pixel altered");
endmodule
`default_nettype wire

// File: rtl/gb5_ram.sv
// ----------------------------------------------------------------------------
// gb5_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gb5_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: test/gb5_tb_pkg.sv
// ----------------------------------------------------------------------------
// gb5_tb_pkg: word types of the Gaussian filter channels
// Payload structs for the pixel input channel and the result channel.
// ----------------------------------------------------------------------------
package gb5_tb_pkg;
	typedef struct packed {
		logic [15:0] pixel;
		logic        drain;
	} pix_in_t;

	typedef struct packed {
		logic [15:0] filtered_pixel;
		logic [11:0] out_row;
		logic [9:0]  out_column;
		logic        last_of_frame;
	} pix_out_t;
endpackage

// File: test/gb5_checker.sv
// ----------------------------------------------------------------------------
// gb5_checker: result predictor and scoreboard of the 5x5 Gaussian filter
// Watches both channels and the register port, runs its own line-store and
// window model on each accepted input word and compares every result word
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module gb5_checker import gb5_pkg::*, gb5_tb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	gb5_stream_if               in_ch,
	gb5_stream_if               out_ch,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN = 1024;

	int unsigned blur_wt [5][5] = '{
		'{1, 4, 7, 4, 1},
		'{4, 16, 26, 16, 4},
		'{7, 26, 41, 26, 7},
		'{4, 16, 26, 16, 4},
		'{1, 4, 7, 4, 1}
	};

	logic [15:0]             line_mem [4][LINE_LEN];
	logic [15:0]             taps [5][5];
	logic [WIDTH_BITS-1:0]   frame_w;
	logic [HEIGHT_BITS-1:0]  frame_h;
	int unsigned             row_pos;
	int unsigned             col_pos;
	pix_out_t                blur_q [$];

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic predict_blur(input pix_in_t w);
		int unsigned wd;
		int unsigned ht;
		int unsigned col;
		int unsigned pos;
		int unsigned lag;
		int unsigned q;
		int unsigned sum;
		logic [15:0] vec [5];
		pix_out_t    res;
		wd = (frame_w == 0) ? 1 : (frame_w > LINE_LEN) ? LINE_LEN : frame_w;
		ht = (frame_h == 0) ? 1 : (frame_h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : frame_h;
		col = (col_pos >= wd) ? 0 : col_pos;
		pos = row_pos * wd + col_pos;
		lag = 2 * wd + 2;
		for (int k = 0; k < 4; k++)
			vec[k] = line_mem[k][col];
		vec[4] = w.drain ? 16'd0 : w.pixel;
		for (int k = 0; k < 4; k++)
			line_mem[k][col] = vec[k + 1];
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 4; c++)
				taps[r][c] = taps[r][c + 1];
			taps[r][4] = vec[r];
		end
		col_pos = col + 1;
		if (col_pos >= wd) begin
			col_pos = 0;
			row_pos++;
		end
		if (pos < lag || pos - lag >= wd * ht)
			return;
		q = pos - lag;
		res.out_row = 12'(q / wd);
		res.out_column = 10'(q % wd);
		if (q / wd >= 2 && q / wd + 2 < ht && q % wd >= 2 && q % wd + 2 < wd) begin
			sum = 0;
			for (int r = 0; r < 5; r++)
				for (int c = 0; c < 5; c++)
					sum += blur_wt[r][c] * taps[r][c];
			res.filtered_pixel = 16'((sum + KERNEL_TOTAL / 2) / KERNEL_TOTAL);
		end else begin
			res.filtered_pixel = taps[2][2];
		end
		res.last_of_frame = (q + 1 == wd * ht);
		if (res.last_of_frame) begin
			row_pos = 0;
			col_pos = 0;
		end
		blur_q.push_back(res);
	endtask

	initial begin
		for (int k = 0; k < 4; k++)
			for (int i = 0; i < LINE_LEN; i++)
				line_mem[k][i] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		pix_out_t got;
		if (!arst_n) begin
			errors = 0;
			frame_w <= 11'd640;
			frame_h <= 13'd480;
			row_pos = 0;
			col_pos = 0;
			for (int r = 0; r < 5; r++)
				for (int c = 0; c < 5; c++)
					taps[r][c] = '0;
			blur_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH)
					frame_w <= cfg_data[WIDTH_BITS-1:0];
				else
					frame_h <= cfg_data[HEIGHT_BITS-1:0];
				row_pos = 0;
				col_pos = 0;
			end
			if (in_ch.valid && in_ch.ready)
				predict_blur(in_ch.data);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (blur_q.size() == 0) begin
					report("unexpected word, pixel", got.filtered_pixel, -1);
				end else begin
					want = blur_q.pop_front();
					if (got.filtered_pixel !== want.filtered_pixel)
						report("filtered_pixel", got.filtered_pixel, want.filtered_pixel);
					if (got.out_row !== want.out_row)
						report("out_row", got.out_row, want.out_row);
					if (got.out_column !== want.out_column)
						report("out_column", got.out_column, want.out_column);
					if (got.last_of_frame !== want.last_of_frame)
						report("last_of_frame", got.last_of_frame, want.last_of_frame);
				end
			end
		end
		pending = blur_q.size();
	end
endmodule

// File: test/tb_gaussian_blur_5x5.sv
// ----------------------------------------------------------------------------
// tb_gaussian_blur_5x5: top of the Gaussian filter testbench
// Writes frame sizes, streams frames with their flush words under varying
// sender and receiver idling, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_5x5 import gb5_pkg::*, gb5_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic                clk = 0;
	logic                arst_n;
	logic                cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	int                  errors;
	int                  pending;
	int                  send_idle;
	int                  recv_stall;
	int                  sent;

	gb5_stream_if #(.T(pix_in_t))  in_ch ();
	gb5_stream_if #(.T(pix_out_t)) out_ch ();

	gaussian_blur_5x5 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gb5_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	initial begin
		#5ms;
		$display("** gaussian_blur_5x5: FAILED **");
		$finish;
	end

	task automatic send_word(input logic [15:0] pixel, input logic drain);
		bit took;
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{pixel: pixel, drain: drain};
		sent++;
		do begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= CFG_BITS'(w);
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= CFG_BITS'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// pattern: 0 random, 1 alternating extremes, 2 all max
	task automatic send_frame(input int unsigned w, input int unsigned h,
			input int pattern, input bit hold_once);
		int unsigned wd;
		int unsigned ht;
		int unsigned n;
		logic [15:0] px;
		wd = (w == 0) ? 1 : (w > 1024) ? 1024 : w;
		ht = (h == 0) ? 1 : (h > 4096) ? 4096 : h;
		n = wd * ht;
		for (int unsigned i = 0; i < n; i++) begin
			case (pattern)
				1: px = i[0] ? 16'hFFFF : 16'h0000;
				2: px = 16'hFFFF;
				default: px = 16'(($urandom_range(9) == 0) ?
						($urandom_range(1) ? 16'hFFFF : 16'h0) : $urandom_range(16'hFFFF));
			endcase
			if (hold_once && i == n / 2) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			send_word(px, pattern == 0 && $urandom_range(19) == 0);
		end
		for (int unsigned i = 0; i < 2 * wd + 2; i++)
			send_word(16'($urandom_range(16'hFFFF)), $urandom_range(4) != 0);
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		send_idle = 0;
		recv_stall = 0;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_frame(5, 5);
		send_frame(5, 5, 2, 0);
		send_frame(5, 5, 1, 0);
		set_frame(0, 0);
		send_frame(0, 0, 0, 0);
		set_frame(6, 5);
		send_frame(6, 5, 0, 0);
		sent = 0;

		for (int mode = 0; mode < 3; mode++) begin
			send_idle = (mode == 0) ? 12 : (mode == 1) ? 75 : 0;
			recv_stall = (mode == 0) ? 75 : (mode == 1) ? 12 : 0;
			while (sent < 240 * (mode + 1)) begin
				if ($urandom_range(2) != 0 || sent == 240 * mode) begin
					w = $urandom_range(1, 12);
					h = $urandom_range(1, 10);
					if ($urandom_range(15) == 0)
						w = 0;
					if ($urandom_range(15) == 0)
						h = 0;
					set_frame(w, h);
				end
				send_frame(w, h, 0, sent == 240 * mode);
			end
		end

		set_frame(40, 5);
		send_frame(40, 5, 0, 0);

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("** gaussian_blur_5x5: PASSED **");
		else
			$display("** gaussian_blur_5x5: FAILED **");
		$finish;
	end
endmodule
